// File: rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared sizes, operation codes and result status codes of the sorted list.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

// File: rtl/sli_if.sv
// ----------------------------------------------------------------------------
// Sorted list channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sli_in_if import sli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface sli_out_if import sli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] value_out;
  logic [OUT_CNT_W-1:0]     count;
  logic                     last;

  modport source (output valid, output status, output value_out, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input value_out, input count,
                  input last, output ready);
endinterface

// File: rtl/sorted_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// Sorted list insert/delete unit
// Keeps up to CAPACITY signed 32-bit values in ascending order in a
// two-port RAM and serves insert, delete and dump requests one at a time.
// Insert walks the list from the top down, moving each value that is not
// smaller one slot up, and drops the new value into the gap (status full
// when the list is already full). Delete walks from the bottom up, finds the
// first equal value and moves every later value one slot down (status not
// found or empty otherwise). Dump returns every stored value in order with
// last set on the final one, or a single empty result. Every other request
// returns exactly one result with last set. The request side is busy from
// acceptance until the final result is loaded into the output register; a
// result may still wait there while the next request is taken. Insert,
// delete and dump visit one stored entry at a time: a read state for the
// registered RAM read, then a compare or output state, so they take longer
// the more values are stored.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit import sli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  sli_in_if.sink           in_i,
  sli_out_if.source        out_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_DEL_RD  = 4'd4;
  localparam logic [3:0] S_DEL_CMP = 4'd5;
  localparam logic [3:0] S_DMP_RD  = 4'd6;
  localparam logic [3:0] S_DMP_OUT = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              found_q, found_d;
  status_e           stat_q, stat_d;

  // Output register
  logic                 ov_q;
  status_e              os_q;
  logic [DATA_W-1:0]    oval_q;
  logic [OUT_CNT_W-1:0] ocnt_q;
  logic                 olast_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Result load
  logic              load;
  status_e           ld_status;
  logic [DATA_W-1:0] ld_val;
  logic              ld_last;

  logic              slot_free;
  logic              last_el;
  logic              not_smaller;
  logic              match;

  sli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign slot_free   = !ov_q || out_o.ready;
  assign last_el     = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(cnt_q);
  // Comparisons on the RAM read data: ordering for insert, equality for delete.
  assign not_smaller = $signed(ram_rdata) >= $signed(val_q);
  assign match       = ram_rdata == val_q;

  assign in_i.ready  = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    found_d   = found_q;
    stat_d    = stat_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    load      = 1'b0;
    ld_status = stat_q;
    ld_val    = '0;
    ld_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          val_d   = in_i.value;
          found_d = 1'b0;
          stat_d  = ST_OK;
          idx_d   = '0;
          unique case (in_i.mode)
            MODE_INSERT: begin
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                stat_d  = ST_FULL;
                state_d = S_FIN;
              end else if (cnt_q == '0) begin
                state_d = S_INS_PUT;
              end else begin
                // Start at the top entry and walk down
                idx_d   = IDX_W'(cnt_q - CNT_W'(1));
                state_d = S_INS_RD;
              end
            end
            MODE_DELETE: begin
              if (cnt_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                state_d = S_DEL_RD;
              end
            end
            MODE_DUMP: begin
              if (cnt_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                state_d = S_DMP_RD;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_INS_RD: begin
        ram_re  = 1'b1;
        state_d = S_INS_CMP;
      end

      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'((CNT_W+1)'(idx_q) + (CNT_W+1)'(1));
        if (not_smaller) begin
          // Move this entry one slot up and keep walking down
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            idx_d   = idx_q - IDX_W'(1);
            state_d = S_INS_RD;
          end
        end else begin
          // Gap found just above this entry
          ram_wdata = val_q;
          cnt_d     = cnt_q + CNT_W'(1);
          state_d   = S_FIN;
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_q;
        cnt_d     = cnt_q + CNT_W'(1);
        state_d   = S_FIN;
      end

      S_DEL_RD: begin
        ram_re  = 1'b1;
        state_d = S_DEL_CMP;
      end

      S_DEL_CMP: begin
        if (found_q) begin
          // Close the gap left by the removed entry
          ram_we    = 1'b1;
          ram_waddr = idx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        found_d = found_q || match;
        if (last_el) begin
          if (found_q || match) begin
            cnt_d  = cnt_q - CNT_W'(1);
            stat_d = ST_OK;
          end else begin
            stat_d = ST_NOT_FOUND;
          end
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_DEL_RD;
        end
      end

      S_DMP_RD: begin
        ram_re  = 1'b1;
        state_d = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        // RAM read data holds while the output is stalled
        if (slot_free) begin
          load      = 1'b1;
          ld_status = ST_OK;
          ld_val    = ram_rdata;
          ld_last   = last_el;
          if (last_el) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_DMP_RD;
          end
        end
      end

      S_FIN: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_status = stat_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    stat_q <= stat_d;
    if (load) begin
      os_q    <= ld_status;
      oval_q  <= ld_val;
      ocnt_q  <= OUT_CNT_W'(cnt_q);
      olast_q <= ld_last;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.status    = os_q;
  assign out_o.value_out = oval_q;
  assign out_o.count     = ocnt_q;
  assign out_o.last      = olast_q;

  // Count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  // Count moves by exactly one, and only when the request finishes
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (state_q == S_FIN) &&
      ((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
    else $error("count changed outside request completion");

  // An accepted request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request side ready right after acceptance");

endmodule

// File: rtl/sli_ram.sv
// ----------------------------------------------------------------------------
// Sorted list RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: bench/sli_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list result checker
// Keeps its own copy of the list from the accepted requests, queues the
// results that each request should cause, and compares every accepted result
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sli_list_checker import sli_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sli_in_if    req_mon,
  sli_out_if   res_mon,
  output int   errors_o,
  output int   pending_o
);

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] value;
    logic [OUT_CNT_W-1:0]     count;
    logic                     last;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int                       shadow_count;
  list_result_t             awaited_q [$];
  int                       error_count;

  function automatic void queue_result(status_e st, logic signed [DATA_W-1:0] v,
                                       logic lst);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.count  = OUT_CNT_W'(shadow_count);
    r.last   = lst;
    awaited_q.push_back(r);
  endfunction

  // Update the shadow list and queue the results of one request.
  task automatic predict_request(mode_e op, logic signed [DATA_W-1:0] v);
    int pos;
    pos = 0;
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          while (pos < shadow_count && shadow_list[pos] < v) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = v;
          shadow_count++;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (shadow_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          while (pos < shadow_count && shadow_list[pos] !== v) pos++;
          if (pos >= shadow_count) begin
            queue_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
            queue_result(ST_OK, '0, 1'b1);
          end
        end
      end
      MODE_DUMP: begin
        if (shadow_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            queue_result(ST_OK, shadow_list[i], i + 1 == shadow_count);
          end
        end
      end
      default: begin
        // unused mode: one plain result, list untouched
        queue_result(ST_OK, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_result();
    list_result_t exp;
    if (awaited_q.size() == 0) begin
      error_count++;
      $display("%0t: expected no result, got status %0d value %0d count %0d last %0d",
               $time, res_mon.status, res_mon.value_out, res_mon.count, res_mon.last);
    end else begin
      exp = awaited_q.pop_front();
      if (res_mon.status !== exp.status) begin
        error_count++;
        $display("%0t: status expected %0d got %0d", $time, exp.status, res_mon.status);
      end
      if (res_mon.value_out !== exp.value) begin
        error_count++;
        $display("%0t: value expected %0d got %0d", $time, exp.value, res_mon.value_out);
      end
      if (res_mon.count !== exp.count) begin
        error_count++;
        $display("%0t: count expected %0d got %0d", $time, exp.count, res_mon.count);
      end
      if (res_mon.last !== exp.last) begin
        error_count++;
        $display("%0t: last expected %0d got %0d", $time, exp.last, res_mon.last);
      end
    end
  endtask

  // Results leave before the new request is predicted, so a result taken at
  // the same edge is always matched against an older request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      awaited_q.delete();
      errors_o  <= error_count;
      pending_o <= 0;
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) check_result();
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        predict_request(mode_e'(req_mon.mode), req_mon.value);
      end
      errors_o  <= error_count;
      pending_o <= awaited_q.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list unit testbench
// Drives insert, delete, dump and unused-mode requests into the sorted list
// unit, first a directed walk through the corner cases, then random phases
// that fill, overflow, churn and empty the list, with random stalls on both
// channels. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import sli_pkg::*;

  localparam int RANDOM_ITEMS  = 420;
  localparam int CALM_ITEMS    = 60;    // final stretch runs without idling
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 64;    // longer than the slowest request

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;

  sli_in_if  req_ch ();
  sli_out_if res_ch ();

  int errors;
  int pending;

  // Idling control for both sides; calm turns all idling off.
  logic calm       = 1'b0;
  int   gap_pct    = 20;
  int   stall_pct  = 20;
  int   quiet_cycles = 0;
  int   requests_sent;

  // Recently inserted values, so deletes mostly hit stored entries.
  logic signed [DATA_W-1:0] kept_q [$];

  sorted_list_insert_delete_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  sli_list_checker list_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_ch),
    .res_mon   (res_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: drop ready in bursts at the stall rate unless calm, hold it otherwise.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no request and no result moves for too long.
  always @(posedge clk_i) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until it is taken; then maybe idle.
  // Valid stays high into the next request when there is no gap, so it is
  // never lowered and raised within one edge.
  task automatic send_request(input mode_e op, input logic signed [DATA_W-1:0] v);
    req_ch.valid <= 1'b1;
    req_ch.mode  <= op;
    req_ch.value <= v;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
    requests_sent++;
    if (op == MODE_INSERT) begin
      kept_q.push_back(v);
      if (kept_q.size() > 24) void'(kept_q.pop_front());
    end
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_W'($urandom_range(0, 3));
      req_ch.value <= $urandom;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic hold_off();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mix extremes, a narrow band that forces duplicates, stored values and
  // full-range values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: return int'($urandom_range(0, 8)) - 4;
      5: if (kept_q.size() > 0) return kept_q[$urandom_range(0, kept_q.size() - 1)];
      default: ;
    endcase
    return $urandom;
  endfunction

  // Delete a value that was inserted earlier most of the time.
  task automatic delete_kept();
    int                       idx;
    logic signed [DATA_W-1:0] v;
    if (kept_q.size() > 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, kept_q.size() - 1);
      v   = kept_q[idx];
      kept_q.delete(idx);
      send_request(MODE_DELETE, v);
    end else begin
      send_request(MODE_DELETE, pick_value());
    end
  endtask

  task automatic run_phase(input int kind);
    int r;
    case (kind)
      0: begin
        // mixed traffic around a partly filled list
        repeat ($urandom_range(20, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 40)      send_request(MODE_INSERT, pick_value());
          else if (r < 70) delete_kept();
          else if (r < 88) send_request(MODE_DUMP, $urandom);
          else if (r < 95) send_request(MODE_DELETE, pick_value());
          else             send_request(MODE_NONE, $urandom);
        end
      end
      1: begin
        // fill past capacity, dump the full list, then thin it out
        repeat ($urandom_range(17, 20)) send_request(MODE_INSERT, pick_value());
        send_request(MODE_DUMP, $urandom);
        repeat ($urandom_range(10, 20)) delete_kept();
        send_request(MODE_DUMP, $urandom);
      end
      2: begin
        // empty the list, then probe it while empty
        repeat ($urandom_range(16, 24)) delete_kept();
        send_request(MODE_DELETE, pick_value());
        send_request(MODE_DUMP, $urandom);
        repeat ($urandom_range(3, 10)) begin
          send_request(MODE_INSERT, int'($urandom_range(0, 8)) - 4);
          if ($urandom_range(0, 2) == 0) send_request(MODE_DUMP, $urandom);
        end
      end
      default: begin
        // noise: any mode, any value
        repeat ($urandom_range(10, 25)) send_request(mode_e'($urandom_range(0, 3)), $urandom);
      end
    endcase
  endtask

  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    int base;
    rst_ni       <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= MODE_INSERT;
    req_ch.value <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, the only value removed, extremes, duplicates,
    // not found, the unused mode, and the list emptied again.
    send_request(MODE_DUMP, '0);
    send_request(MODE_DELETE, 32'sd5);
    send_request(MODE_NONE, VAL_MAX);
    send_request(MODE_INSERT, 32'sd42);
    send_request(MODE_DELETE, 32'sd42);
    send_request(MODE_DUMP, VAL_MIN);
    send_request(MODE_INSERT, VAL_MAX);
    send_request(MODE_INSERT, VAL_MIN);
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_INSERT, -32'sd1);
    send_request(MODE_INSERT, 32'sd1);
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_DUMP, '0);
    send_request(MODE_DELETE, 32'sd7);
    send_request(MODE_DELETE, VAL_MIN);
    send_request(MODE_NONE, -32'sd1);
    send_request(MODE_DELETE, 32'sd0);
    send_request(MODE_DUMP, '0);
    send_request(MODE_DELETE, 32'sd0);
    send_request(MODE_DELETE, -32'sd1);
    send_request(MODE_DELETE, 32'sd1);
    send_request(MODE_DELETE, VAL_MAX);
    send_request(MODE_DUMP, '0);
    kept_q.delete();

    // Let the directed part drain completely before the random phases.
    hold_off();

    base = requests_sent;
    while (requests_sent - base < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - (requests_sent - base) <= CALM_ITEMS) begin
        calm = 1'b1;
      end else begin
        gap_pct   = pick_rate();
        stall_pct = pick_rate();
      end
      run_phase($urandom_range(0, 3));
      if (!calm && $urandom_range(0, 3) == 0) hold_off();
    end

    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sorted_list_insert_delete_unit.f
rtl/sli_pkg.sv
rtl/sli_if.sv
rtl/sli_ram.sv
rtl/sorted_list_insert_delete_unit.sv
bench/sli_list_checker.sv
bench/testbench.sv
